### design/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// shared constants, codes and types of the sorted timeout release list
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // operations
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_VERDICT = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // result kinds
    localparam logic [2:0] RK_ADD_ACK  = 3'd0;
    localparam logic [2:0] RK_DEL_ACK  = 3'd1;
    localparam logic [2:0] RK_EXPIRED  = 3'd2;
    localparam logic [2:0] RK_CLEARED  = 3'd3;
    localparam logic [2:0] RK_VERD_ACK = 3'd4;
    localparam logic [2:0] RK_DONE     = 3'd5;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_TO    = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    // slot status
    localparam logic [1:0] SLOT_FREE    = 2'd0;
    localparam logic [1:0] SLOT_ARMED   = 2'd1;
    localparam logic [1:0] SLOT_PENDING = 2'd2;

    // register addresses
    localparam logic [2:0] ADDR_MAX_PER_TICK = 3'd0;
    localparam logic [5:0] MAX_PER_TICK_RST  = 6'd32;

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] timeout;
        logic [31:0] id;
        logic [1:0]  status;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  status;
        logic [31:0] id;
        logic        forced;
        logic        last;
        logic [5:0]  active;
    } t_result;

endpackage

### design/stl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_mem
// entry store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module stl_mem (
    input  logic              i_clk,
    input  stl_pkg::t_mem_req i_req,
    output stl_pkg::t_entry   o_rd_data
);

    stl_pkg::t_entry r_mem [stl_pkg::CAPACITY];
    stl_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/stl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_seq
// sequencer: scans, shifts and rewrites the entry store, produces results
// ----------------------------------------------------------------------------
module stl_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_operation,
    input  logic [31:0]                 i_now_time,
    input  logic [31:0]                 i_timeout_len,
    input  logic [31:0]                 i_entry_ref,
    input  logic                        i_retry,
    input  logic [stl_pkg::CNT_W-1:0]   i_lim,
    input  logic                        i_out_free,
    output logic                        o_res_valid,
    output stl_pkg::t_result            o_res,
    output stl_pkg::t_mem_req           o_mem,
    input  stl_pkg::t_entry             i_rd_data
);

    localparam int CW = stl_pkg::CNT_W;
    localparam int IW = stl_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_INS_SHIFT, S_INS_WR, S_REM_SHIFT, S_ACK, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        M_ADD, M_DEL, M_VER, M_TCNT, M_TEMIT, M_CLR
    } t_mode;

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [CW-1:0] r_ra, n_ra;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_di, n_di;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_armed, n_armed;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_ecnt, n_ecnt;
    logic [31:0]   r_last_id, n_last_id;
    logic [31:0]   r_exp, n_exp;
    logic [31:0]   r_to, n_to;
    logic [31:0]   r_id, n_id;
    logic [31:0]   r_now, n_now;
    logic          r_retry, n_retry;
    logic [2:0]    r_ack_kind, n_ack_kind;
    logic [1:0]    r_ack_st, n_ack_st;
    logic [31:0]   r_ack_id, n_ack_id;

    logic          d_armed, d_pend, need_out, consume, hit, issue;
    logic [31:0]   new_id;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_ra       = r_ra;
        n_dv       = r_dv;
        n_di       = r_di;
        n_pos      = r_pos;
        n_used     = r_used;
        n_armed    = r_armed;
        n_cnt      = r_cnt;
        n_ecnt     = r_ecnt;
        n_last_id  = r_last_id;
        n_exp      = r_exp;
        n_to       = r_to;
        n_id       = r_id;
        n_now      = r_now;
        n_retry    = r_retry;
        n_ack_kind = r_ack_kind;
        n_ack_st   = r_ack_st;
        n_ack_id   = r_ack_id;

        o_mem         = '0;
        o_res_valid   = 1'b0;
        o_res         = '0;
        o_res.active  = 6'(r_armed);
        o_in_ready    = (r_state == S_IDLE);

        d_armed  = (i_rd_data.status == stl_pkg::SLOT_ARMED);
        d_pend   = (i_rd_data.status == stl_pkg::SLOT_PENDING);
        need_out = (r_mode == M_CLR) || ((r_mode == M_TEMIT) && d_armed);
        consume  = r_dv && (!need_out || i_out_free);
        hit      = 1'b0;
        issue    = 1'b0;
        new_id   = r_last_id + 32'd1;
        if (new_id == 32'd0) begin
            new_id = 32'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ra = '0;
                    n_dv = 1'b0;
                    case (i_operation)
                        stl_pkg::OP_ADD: begin
                            n_ack_kind = stl_pkg::RK_ADD_ACK;
                            n_ack_id   = '0;
                            if (i_timeout_len == 32'd0) begin
                                n_ack_st = stl_pkg::STS_BAD_TO;
                                n_state  = S_ACK;
                            end else if (r_used >= CW'(stl_pkg::CAPACITY)) begin
                                n_ack_st = stl_pkg::STS_FULL;
                                n_state  = S_ACK;
                            end else begin
                                n_last_id = new_id;
                                n_id      = new_id;
                                n_exp     = i_now_time + i_timeout_len;
                                n_to      = i_timeout_len;
                                n_ack_st  = stl_pkg::STS_OK;
                                n_ack_id  = new_id;
                                n_mode    = M_ADD;
                                n_state   = S_SCAN;
                            end
                        end
                        stl_pkg::OP_DELETE: begin
                            n_id       = i_entry_ref;
                            n_ack_kind = stl_pkg::RK_DEL_ACK;
                            n_mode     = M_DEL;
                            n_state    = S_SCAN;
                        end
                        stl_pkg::OP_TICK: begin
                            n_now   = i_now_time;
                            n_cnt   = '0;
                            n_mode  = M_TCNT;
                            n_state = S_SCAN;
                        end
                        stl_pkg::OP_VERDICT: begin
                            n_id       = i_entry_ref;
                            n_now      = i_now_time;
                            n_retry    = i_retry;
                            n_ack_kind = stl_pkg::RK_VERD_ACK;
                            n_mode     = M_VER;
                            n_state    = S_SCAN;
                        end
                        stl_pkg::OP_CLEAR: begin
                            n_armed = '0;
                            n_mode  = M_CLR;
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // look at the entry whose read came back
                if (consume) begin
                    case (r_mode)
                        M_ADD: begin
                            hit = d_armed && (i_rd_data.expiry > r_exp);
                            if (hit) begin
                                n_pos   = CW'(r_di);
                                n_ra    = r_used;
                                n_state = S_INS_SHIFT;
                            end
                        end
                        M_DEL, M_VER: begin
                            hit = (i_rd_data.id == r_id) &&
                                  ((r_mode == M_DEL) ? d_armed : d_pend);
                            if (hit) begin
                                n_pos   = CW'(r_di);
                                n_to    = i_rd_data.timeout;
                                n_ra    = CW'(r_di) + CW'(1);
                                n_state = S_REM_SHIFT;
                            end
                        end
                        M_TCNT: begin
                            if (d_armed) begin
                                if (i_rd_data.expiry > r_now || r_cnt >= i_lim) begin
                                    hit = 1'b1;
                                end else begin
                                    n_cnt = r_cnt + CW'(1);
                                end
                            end
                        end
                        M_TEMIT: begin
                            if (d_armed) begin
                                o_res_valid = 1'b1;
                                o_res.kind  = stl_pkg::RK_EXPIRED;
                                o_res.id    = i_rd_data.id;
                                o_mem.we      = 1'b1;
                                o_mem.wr_addr = r_di;
                                o_mem.wr_data = i_rd_data;
                                o_mem.wr_data.status = stl_pkg::SLOT_PENDING;
                                n_ecnt = r_ecnt + CW'(1);
                                if (r_ecnt + CW'(1) == r_cnt) begin
                                    hit     = 1'b1;
                                    n_state = S_DONE;
                                end
                            end
                        end
                        M_CLR: begin
                            o_res_valid  = 1'b1;
                            o_res.kind   = stl_pkg::RK_CLEARED;
                            o_res.id     = i_rd_data.id;
                            o_res.forced = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end

                issue = !hit && (!r_dv || consume) && (r_ra < r_used);
                if (issue) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_ra[IW-1:0];
                    n_di = r_ra[IW-1:0];
                    n_ra = r_ra + CW'(1);
                end
                n_dv = issue || (r_dv && !consume);

                // tick count pass finished, by a stop or at the end of the list
                if ((r_mode == M_TCNT) &&
                    (hit || (!issue && (!r_dv || consume)))) begin
                    n_armed = r_armed - n_cnt;
                    n_dv    = 1'b0;
                    n_ra    = '0;
                    n_ecnt  = '0;
                    if (n_cnt == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_mode = M_TEMIT;
                    end
                end else if (!hit && !issue && (!r_dv || consume)) begin
                    // end of the list without a match
                    case (r_mode)
                        M_ADD: begin
                            n_pos   = r_used;
                            n_ra    = r_used;
                            n_state = S_INS_SHIFT;
                        end
                        M_DEL, M_VER: begin
                            n_ack_st = stl_pkg::STS_NOT_FOUND;
                            n_ack_id = '0;
                            n_state  = S_ACK;
                        end
                        M_CLR: begin
                            n_used  = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_INS_SHIFT: begin
                // move entries pos..used-1 up by one, top first
                if (r_dv) begin
                    o_mem.we      = 1'b1;
                    o_mem.wr_addr = r_di + IW'(1);
                    o_mem.wr_data = i_rd_data;
                end
                issue = (r_ra > r_pos);
                if (issue) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = IW'(r_ra - CW'(1));
                    n_di = IW'(r_ra - CW'(1));
                    n_ra = r_ra - CW'(1);
                end
                n_dv = issue;
                if (!issue && !r_dv) begin
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                o_mem.we             = 1'b1;
                o_mem.wr_addr        = r_pos[IW-1:0];
                o_mem.wr_data.expiry = r_exp;
                o_mem.wr_data.timeout = r_to;
                o_mem.wr_data.id     = r_id;
                o_mem.wr_data.status = stl_pkg::SLOT_ARMED;
                n_used   = r_used + CW'(1);
                n_armed  = r_armed + CW'(1);
                n_ack_st = stl_pkg::STS_OK;
                n_ack_id = r_id;
                n_state  = S_ACK;
            end

            S_REM_SHIFT: begin
                // move entries pos+1..used-1 down by one
                if (r_dv) begin
                    o_mem.we      = 1'b1;
                    o_mem.wr_addr = r_di - IW'(1);
                    o_mem.wr_data = i_rd_data;
                end
                issue = (r_ra < r_used);
                if (issue) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_ra[IW-1:0];
                    n_di = r_ra[IW-1:0];
                    n_ra = r_ra + CW'(1);
                end
                n_dv = issue;
                if (!issue && !r_dv) begin
                    n_used   = r_used - CW'(1);
                    n_ack_st = stl_pkg::STS_OK;
                    n_ack_id = r_id;
                    if (r_mode == M_DEL) begin
                        n_armed = r_armed - CW'(1);
                        n_state = S_ACK;
                    end else if (r_retry) begin
                        // re-arm: search the insert position again
                        n_exp   = r_now + r_to;
                        n_mode  = M_ADD;
                        n_ra    = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_ACK;
                    end
                end
            end

            S_ACK: begin
                o_res_valid  = 1'b1;
                o_res.kind   = r_ack_kind;
                o_res.status = r_ack_st;
                o_res.id     = r_ack_id;
                o_res.last   = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                o_res.kind  = stl_pkg::RK_DONE;
                o_res.last  = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= M_ADD;
            r_dv      <= 1'b0;
            r_used    <= '0;
            r_armed   <= '0;
            r_last_id <= '0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_dv      <= n_dv;
            r_used    <= n_used;
            r_armed   <= n_armed;
            r_last_id <= n_last_id;
        end
        r_ra       <= n_ra;
        r_di       <= n_di;
        r_pos      <= n_pos;
        r_cnt      <= n_cnt;
        r_ecnt     <= n_ecnt;
        r_exp      <= n_exp;
        r_to       <= n_to;
        r_id       <= n_id;
        r_now      <= n_now;
        r_retry    <= n_retry;
        r_ack_kind <= n_ack_kind;
        r_ack_st   <= n_ack_st;
        r_ack_id   <= n_ack_id;
    end

endmodule

### design/sorted_timeout_release_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_release_list
// timeout entries kept in expiry order in one entry store; add, delete,
// tick, verdict and clear items, with a max_per_tick register
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     operation, now, timeout, ref, retry
//  result    out        o_out_valid / i_out_ready   kind, status, id, forced, last, count
//  config    in         psel, penable, pwrite       paddr, pwdata, prdata (max_per_tick)
//
//  one item at a time; an add scans for its place, shifts entries up and writes it;
//  a delete or verdict scans and shifts entries down; a re-arming verdict then scans,
//  shifts up and writes once more; a tick counts due entries, then emits; a clear
//  emits every entry; the single read port gives one slot read per cycle unless stalled
//  synchronous active-low reset empties the list through the fill count, no sweep
//  a stalled result stops a tick or clear scan in place; emission resumes when it is taken
// ----------------------------------------------------------------------------
module sorted_timeout_release_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_now_time,
    input  logic [31:0] i_timeout_len,
    input  logic [31:0] i_entry_ref,
    input  logic        i_retry,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_result_kind,
    output logic [1:0]  o_status,
    output logic [31:0] o_entry_id,
    output logic        o_forced,
    output logic        o_last,
    output logic [5:0]  o_active_count,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = stl_pkg::CNT_W;

    logic [5:0]        r_max_per_tick;
    logic [CW-1:0]     lim;
    logic              out_free;
    logic              res_valid;
    stl_pkg::t_result  res;
    stl_pkg::t_mem_req mem_req;
    stl_pkg::t_entry   rd_data;
    logic              r_out_valid;
    stl_pkg::t_result  r_out;

    // register port, always ready
    assign pready = 1'b1;
    assign prdata = (paddr == stl_pkg::ADDR_MAX_PER_TICK) ? {26'd0, r_max_per_tick} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_per_tick <= stl_pkg::MAX_PER_TICK_RST;
        end else if (psel && penable && pwrite && pready &&
                     paddr == stl_pkg::ADDR_MAX_PER_TICK) begin
            r_max_per_tick <= pwdata[5:0];
        end
    end

    // per-tick cap: zero acts as one, anything above capacity as capacity
    always_comb begin
        if (r_max_per_tick == 6'd0) begin
            lim = CW'(1);
        end else if (int'(r_max_per_tick) > stl_pkg::CAPACITY) begin
            lim = CW'(stl_pkg::CAPACITY);
        end else begin
            lim = CW'(r_max_per_tick);
        end
    end

    // result register between the sequencer and the consumer
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
        if (out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out.kind;
    assign o_status       = r_out.status;
    assign o_entry_id     = r_out.id;
    assign o_forced       = r_out.forced;
    assign o_last         = r_out.last;
    assign o_active_count = r_out.active;

    stl_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_now_time    (i_now_time),
        .i_timeout_len (i_timeout_len),
        .i_entry_ref   (i_entry_ref),
        .i_retry       (i_retry),
        .i_lim         (lim),
        .i_out_free    (out_free),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_mem         (mem_req),
        .i_rd_data     (rd_data)
    );

    stl_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule
